[design/tcws_pkg.sv]
package tcws_pkg;

    // Store geometry: each row holds MAX_COLS character cells and one terminator cell
    localparam int MAX_ROWS = 4;
    localparam int MAX_COLS = 20;
    localparam int ROW_LEN  = MAX_COLS + 1;
    localparam int CELLS    = MAX_ROWS * ROW_LEN;
    localparam int ADDR_W   = $clog2(CELLS);

    // Field widths fixed by the request and result formats
    localparam int ROW_W   = 2;
    localparam int COL_W   = 5;
    localparam int BYTE_W  = 8;
    localparam int TYPE_W  = 2;
    localparam int CIDX_W  = 2;
    localparam int CDATA_W = 8;
    localparam int AROW_W  = 3;

    // Width and row count in use straight after reset
    localparam int RESET_COLS = (MAX_COLS < 20) ? MAX_COLS : 20;
    localparam int RESET_ROWS = (MAX_ROWS < 4) ? MAX_ROWS : 4;

    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'd32;
    localparam logic [BYTE_W-1:0] CH_NUL     = 8'd0;

    // Request types
    localparam logic [TYPE_W-1:0] REQ_APPEND = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_CLEAR  = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_READ   = 2'd2;
    localparam logic [TYPE_W-1:0] REQ_NOP    = 2'd3;

    // Register indexes
    localparam logic [CIDX_W-1:0] CFG_COLS = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_ROWS = 2'd1;

    // Port bundle of the cell store
    typedef struct packed {
        logic                we;
        logic [ADDR_W-1:0]   waddr;
        logic [BYTE_W-1:0]   wdata;
        logic                re;
        logic [ADDR_W-1:0]   raddr;
        logic [BYTE_W-1:0]   rfill;
    } mem_req_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        cell_addr = ADDR_W'(int'(row) * ROW_LEN + int'(col));
    endfunction

    // Byte a cell holds before it is first written
    function automatic logic [BYTE_W-1:0] reset_fill(input logic [COL_W-1:0] col);
        reset_fill = (int'(col) < RESET_COLS) ? CH_SPACE : CH_NUL;
    endfunction

endpackage

[design/tcws_cell_ram.sv]
module tcws_cell_ram (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tcws_pkg::mem_req_t            mreq,
    output logic [tcws_pkg::BYTE_W-1:0]   rdata
);

    logic [tcws_pkg::BYTE_W-1:0] mem [tcws_pkg::CELLS];
    logic [tcws_pkg::CELLS-1:0]  vld_reg;
    logic [tcws_pkg::BYTE_W-1:0] mem_q_reg;
    logic [tcws_pkg::BYTE_W-1:0] fill_q_reg;
    logic                        vld_q_reg;

    always_ff @(posedge clk)
    begin
        if (mreq.we)
        begin
            mem[mreq.waddr] <= mreq.wdata;
        end
        if (mreq.re)
        begin
            mem_q_reg  <= mem[mreq.raddr];
            fill_q_reg <= mreq.rfill;
        end
    end

    // Mark written cells; an unwritten cell reads as its reset byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            vld_q_reg <= 1'b0;
        end
        else
        begin
            if (mreq.we)
            begin
                vld_reg[mreq.waddr] <= 1'b1;
            end
            if (mreq.re)
            begin
                vld_q_reg <= vld_reg[mreq.raddr];
            end
        end
    end

    assign rdata = vld_q_reg ? mem_q_reg : fill_q_reg;

endmodule

[design/text_console_wrap_scroll.sv]
// Channel   | Direction | Handshake             | Payload
// in        | request   | in_valid / in_stall   | req_type, char_code, read_row, read_col
// out       | result    | out_valid / out_stall | read_data, cursor_row, cursor_col
// cfg       | write     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One request at a time; appends, clears and reads go through the cell store, which
// has one write and one read port. Append writes the character, then a terminator
// behind it; a read sends the address, then takes the data; a no-op only returns its
// result. A new line blanks and terminates the new row; a scroll first copies each
// row up, 21 cells a row, one cell per cycle. Clear all blanks every active row.
// Reset clears per-cell valid flags at once, so no clearing pass is needed.
// A finished result waits in the output register while the next request is taken.
module text_console_wrap_scroll (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [tcws_pkg::TYPE_W-1:0]    req_type,
    input  logic [tcws_pkg::BYTE_W-1:0]    char_code,
    input  logic [tcws_pkg::ROW_W-1:0]     read_row,
    input  logic [tcws_pkg::COL_W-1:0]     read_col,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [tcws_pkg::BYTE_W-1:0]    read_data,
    output logic [tcws_pkg::ROW_W-1:0]     cursor_row,
    output logic [tcws_pkg::COL_W-1:0]     cursor_col,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tcws_pkg::CIDX_W-1:0]    cfg_index,
    input  logic [tcws_pkg::CDATA_W-1:0]   cfg_data
);

    localparam int ROW_W  = tcws_pkg::ROW_W;
    localparam int COL_W  = tcws_pkg::COL_W;
    localparam int BYTE_W = tcws_pkg::BYTE_W;
    localparam int AROW_W = tcws_pkg::AROW_W;

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_ADVANCE   = 4'd1;
    localparam logic [3:0] ST_CLR_ROW   = 4'd2;
    localparam logic [3:0] ST_SCROLL    = 4'd3;
    localparam logic [3:0] ST_SCR_TAIL  = 4'd4;
    localparam logic [3:0] ST_APP_CHAR  = 4'd5;
    localparam logic [3:0] ST_APP_TERM  = 4'd6;
    localparam logic [3:0] ST_RD_ADDR   = 4'd7;
    localparam logic [3:0] ST_RD_DATA   = 4'd8;
    localparam logic [3:0] ST_FINISH    = 4'd9;

    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(tcws_pkg::MAX_COLS);
    localparam logic [AROW_W-1:0] ROWS_MAX  = AROW_W'(tcws_pkg::MAX_ROWS);

    logic [3:0]          state_reg, state_next;
    logic [BYTE_W-1:0]   ch_reg;
    logic [ROW_W-1:0]    rrow_reg;
    logic [COL_W-1:0]    rcol_reg;

    logic                pend_reg, pend_next;         // character waits behind a new line
    logic                clr_all_reg, clr_all_next;
    logic [ROW_W-1:0]    line_reg, line_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    crow_reg, crow_next;
    logic [COL_W-1:0]    ccol_reg, ccol_next;
    logic [ROW_W-1:0]    srow_reg, srow_next;
    logic [COL_W-1:0]    scol_reg, scol_next;
    logic                wpend_reg, wpend_next;
    logic [ROW_W-1:0]    wrow_reg, wrow_next;
    logic [COL_W-1:0]    wcol_reg, wcol_next;
    logic                ended_reg, ended_next;
    logic [BYTE_W-1:0]   rdata_reg, rdata_next;

    logic [COL_W-1:0]    act_cols_reg, act_cols_next;
    logic [AROW_W-1:0]   act_rows_reg, act_rows_next;

    logic                out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]   out_data_reg, out_data_next;
    logic [ROW_W-1:0]    out_row_reg, out_row_next;
    logic [COL_W-1:0]    out_col_reg, out_col_next;

    tcws_pkg::mem_req_t  mreq;
    logic [BYTE_W-1:0]   ram_rdata;

    logic                in_take;
    logic [BYTE_W-1:0]   copy_byte;
    logic                rd_in_range;
    logic                out_free;
    logic [ROW_W-1:0]    last_row;
    logic [COL_W-1:0]    cfg_cols_sat;
    logic [AROW_W-1:0]   cfg_rows_sat;

    tcws_cell_ram u_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .mreq  (mreq),
        .rdata (ram_rdata)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign last_row  = ROW_W'(act_rows_reg - AROW_W'(1));

    // Copy bytes up to the first zero of the source row, zeros after it
    assign copy_byte = (ended_reg && (wcol_reg != '0)) ? tcws_pkg::CH_NUL : ram_rdata;

    assign rd_in_range = (int'(rrow_reg) < tcws_pkg::MAX_ROWS) &&
                         (int'(rcol_reg) < tcws_pkg::ROW_LEN);

    // Saturate register writes into their legal range
    always_comb
    begin
        cfg_cols_sat = cfg_data[COL_W-1:0];
        if (cfg_cols_sat == '0)
        begin
            cfg_cols_sat = COL_W'(1);
        end
        else if (cfg_cols_sat > LAST_COL)
        begin
            cfg_cols_sat = LAST_COL;
        end
        cfg_rows_sat = cfg_data[AROW_W-1:0];
        if (cfg_rows_sat == '0)
        begin
            cfg_rows_sat = AROW_W'(1);
        end
        else if (cfg_rows_sat > ROWS_MAX)
        begin
            cfg_rows_sat = ROWS_MAX;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        pend_next     = pend_reg;
        clr_all_next  = clr_all_reg;
        line_next     = line_reg;
        col_next      = col_reg;
        crow_next     = crow_reg;
        ccol_next     = ccol_reg;
        srow_next     = srow_reg;
        scol_next     = scol_reg;
        wpend_next    = 1'b0;
        wrow_next     = wrow_reg;
        wcol_next     = wcol_reg;
        ended_next    = ended_reg;
        rdata_next    = rdata_reg;
        act_cols_next = act_cols_reg;
        act_rows_next = act_rows_reg;
        mreq          = '0;

        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;

        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == tcws_pkg::CFG_COLS)
            begin
                act_cols_next = cfg_cols_sat;
            end
            else if (cfg_index == tcws_pkg::CFG_ROWS)
            begin
                act_rows_next = cfg_rows_sat;
            end
        end

        // Drain the copy pipeline: write the byte read in the previous cycle
        if (wpend_reg)
        begin
            mreq.we    = 1'b1;
            mreq.waddr = tcws_pkg::cell_addr(wrow_reg, wcol_reg);
            mreq.wdata = copy_byte;
            ended_next = (copy_byte == tcws_pkg::CH_NUL);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    rdata_next   = tcws_pkg::CH_NUL;
                    clr_all_next = 1'b0;
                    pend_next    = 1'b0;
                    case (req_type)
                        tcws_pkg::REQ_APPEND:
                        begin
                            if (char_code == tcws_pkg::CH_NEWLINE)
                            begin
                                state_next = ST_ADVANCE;
                            end
                            else if (col_reg >= act_cols_reg)
                            begin
                                pend_next  = 1'b1;
                                state_next = ST_ADVANCE;
                            end
                            else
                            begin
                                state_next = ST_APP_CHAR;
                            end
                        end
                        tcws_pkg::REQ_CLEAR:
                        begin
                            clr_all_next = 1'b1;
                            line_next    = '0;
                            col_next     = '0;
                            crow_next    = '0;
                            ccol_next    = '0;
                            state_next   = ST_CLR_ROW;
                        end
                        tcws_pkg::REQ_READ:
                        begin
                            state_next = ST_RD_ADDR;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            ST_ADVANCE:
            begin
                col_next  = '0;
                ccol_next = '0;
                if (({1'b0, line_reg} + AROW_W'(1)) < act_rows_reg)
                begin
                    line_next  = line_reg + ROW_W'(1);
                    crow_next  = line_reg + ROW_W'(1);
                    state_next = ST_CLR_ROW;
                end
                else if (act_rows_reg > AROW_W'(1))
                begin
                    srow_next  = '0;
                    scol_next  = '0;
                    ended_next = 1'b0;
                    state_next = ST_SCROLL;
                end
                else
                begin
                    line_next  = last_row;
                    crow_next  = last_row;
                    state_next = ST_CLR_ROW;
                end
            end

            ST_SCROLL:
            begin
                // Read row r+1 now, write row r next cycle
                mreq.re    = 1'b1;
                mreq.raddr = tcws_pkg::cell_addr(srow_reg + ROW_W'(1), scol_reg);
                mreq.rfill = tcws_pkg::reset_fill(scol_reg);
                wpend_next = 1'b1;
                wrow_next  = srow_reg;
                wcol_next  = scol_reg;
                if (scol_reg == LAST_COL)
                begin
                    scol_next = '0;
                    if (({1'b0, srow_reg} + AROW_W'(2)) == act_rows_reg)
                    begin
                        state_next = ST_SCR_TAIL;
                    end
                    else
                    begin
                        srow_next = srow_reg + ROW_W'(1);
                    end
                end
                else
                begin
                    scol_next = scol_reg + COL_W'(1);
                end
            end

            ST_SCR_TAIL:
            begin
                line_next  = last_row;
                crow_next  = last_row;
                ccol_next  = '0;
                state_next = ST_CLR_ROW;
            end

            ST_CLR_ROW:
            begin
                mreq.we    = 1'b1;
                mreq.waddr = tcws_pkg::cell_addr(crow_reg, ccol_reg);
                mreq.wdata = (ccol_reg == act_cols_reg) ? tcws_pkg::CH_NUL : tcws_pkg::CH_SPACE;
                if (ccol_reg == act_cols_reg)
                begin
                    ccol_next = '0;
                    if (clr_all_reg && (({1'b0, crow_reg} + AROW_W'(1)) < act_rows_reg))
                    begin
                        crow_next = crow_reg + ROW_W'(1);
                    end
                    else if (pend_reg)
                    begin
                        state_next = ST_APP_CHAR;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
                else
                begin
                    ccol_next = ccol_reg + COL_W'(1);
                end
            end

            ST_APP_CHAR:
            begin
                mreq.we    = 1'b1;
                mreq.waddr = tcws_pkg::cell_addr(line_reg, col_reg);
                mreq.wdata = ch_reg;
                col_next   = col_reg + COL_W'(1);
                state_next = ST_APP_TERM;
            end

            ST_APP_TERM:
            begin
                mreq.we    = 1'b1;
                mreq.waddr = tcws_pkg::cell_addr(line_reg, col_reg);
                mreq.wdata = tcws_pkg::CH_NUL;
                state_next = ST_FINISH;
            end

            ST_RD_ADDR:
            begin
                mreq.re    = rd_in_range;
                mreq.raddr = tcws_pkg::cell_addr(rrow_reg, rcol_reg);
                mreq.rfill = tcws_pkg::reset_fill(rcol_reg);
                state_next = ST_RD_DATA;
            end

            ST_RD_DATA:
            begin
                rdata_next = rd_in_range ? ram_rdata : tcws_pkg::CH_NUL;
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                // Hold until the output register can take the result
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = rdata_reg;
                    out_row_next   = line_reg;
                    out_col_next   = col_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            clr_all_reg   <= 1'b0;
            line_reg      <= '0;
            col_reg       <= '0;
            crow_reg      <= '0;
            ccol_reg      <= '0;
            srow_reg      <= '0;
            scol_reg      <= '0;
            wpend_reg     <= 1'b0;
            ended_reg     <= 1'b0;
            act_cols_reg  <= COL_W'(tcws_pkg::RESET_COLS);
            act_rows_reg  <= AROW_W'(tcws_pkg::RESET_ROWS);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            clr_all_reg   <= clr_all_next;
            line_reg      <= line_next;
            col_reg       <= col_next;
            crow_reg      <= crow_next;
            ccol_reg      <= ccol_next;
            srow_reg      <= srow_next;
            scol_reg      <= scol_next;
            wpend_reg     <= wpend_next;
            ended_reg     <= ended_next;
            act_cols_reg  <= act_cols_next;
            act_rows_reg  <= act_rows_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: capture the request, hold the result
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            ch_reg   <= char_code;
            rrow_reg <= read_row;
            rcol_reg <= read_col;
        end
        wrow_reg     <= wrow_next;
        wcol_reg     <= wcol_next;
        rdata_reg    <= rdata_next;
        out_data_reg <= out_data_next;
        out_row_reg  <= out_row_next;
        out_col_reg  <= out_col_next;
    end

    assign out_valid  = out_valid_reg;
    assign read_data  = out_data_reg;
    assign cursor_row = out_row_reg;
    assign cursor_col = out_col_reg;

endmodule

[design/tcws_checker.sv]
module tcws_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [tcws_pkg::BYTE_W-1:0]   read_data,
    input logic [tcws_pkg::COL_W-1:0]    cursor_col
);

    // A held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(cursor_col))
        else $error("result dropped or changed while stalled");

    // An accepted request puts the block to work
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted but block not busy");

    // A fresh result only follows a busy period
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without work");

    // Cursor column never passes the terminator cell
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cursor_col <= tcws_pkg::COL_W'(tcws_pkg::MAX_COLS)))
        else $error("cursor column out of range");

endmodule

bind text_console_wrap_scroll tcws_checker u_tcws_checker (.*);

[bench/text_console_wrap_scroll_tb.sv]
`timescale 1ns / 100ps

module text_console_wrap_scroll_tb;

    localparam int ROW_W      = tcws_pkg::ROW_W;
    localparam int COL_W      = tcws_pkg::COL_W;
    localparam int BYTE_W     = tcws_pkg::BYTE_W;
    localparam int TYPE_W     = tcws_pkg::TYPE_W;
    localparam int CIDX_W     = tcws_pkg::CIDX_W;
    localparam int CDATA_W    = tcws_pkg::CDATA_W;
    localparam int AROW_W     = tcws_pkg::AROW_W;
    localparam int MAX_ROWS   = tcws_pkg::MAX_ROWS;
    localparam int MAX_COLS   = tcws_pkg::MAX_COLS;
    localparam int ROW_LEN    = tcws_pkg::ROW_LEN;
    localparam int RESET_COLS = tcws_pkg::RESET_COLS;
    localparam int RESET_ROWS = tcws_pkg::RESET_ROWS;

    localparam logic [BYTE_W-1:0] CH_NEWLINE = tcws_pkg::CH_NEWLINE;
    localparam logic [BYTE_W-1:0] CH_SPACE   = tcws_pkg::CH_SPACE;
    localparam logic [BYTE_W-1:0] CH_NUL     = tcws_pkg::CH_NUL;

    localparam logic [TYPE_W-1:0] REQ_APPEND = tcws_pkg::REQ_APPEND;
    localparam logic [TYPE_W-1:0] REQ_CLEAR  = tcws_pkg::REQ_CLEAR;
    localparam logic [TYPE_W-1:0] REQ_READ   = tcws_pkg::REQ_READ;
    localparam logic [TYPE_W-1:0] REQ_NOP    = tcws_pkg::REQ_NOP;

    localparam logic [CIDX_W-1:0] CFG_COLS = tcws_pkg::CFG_COLS;
    localparam logic [CIDX_W-1:0] CFG_ROWS = tcws_pkg::CFG_ROWS;

    // Generous ceiling: slowest request (scroll on a full 20x4 screen)
    // plus the longest output stall and sender gap, for every request, several times over.
    localparam int LIMIT      = 800000;
    localparam int PHASES     = 9;
    localparam int PHASE_REQS = 160;
    localparam int LOG_CAP    = 50;

    // Register index that the block has no register behind; a write must change nothing
    localparam logic [CIDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } reply_t;

    // One line of the directed plan. A configuration line carries the register
    // index in row and the write data in ch. Lines with typed set carry their
    // own expected reply; all others are checked against the screen model.
    typedef struct packed {
        logic              is_cfg;
        logic              typed;
        logic [TYPE_W-1:0] req;
        logic [BYTE_W-1:0] ch;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        reply_t            want;
    } step_t;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                in_valid   = 1'b0;
    logic                in_stall;
    logic [TYPE_W-1:0]   req_type   = REQ_NOP;
    logic [BYTE_W-1:0]   char_code  = CH_NUL;
    logic [ROW_W-1:0]    read_row   = '0;
    logic [COL_W-1:0]    read_col   = '0;
    logic                out_valid;
    logic                out_stall  = 1'b0;
    logic [BYTE_W-1:0]   read_data;
    logic [ROW_W-1:0]    cursor_row;
    logic [COL_W-1:0]    cursor_col;
    logic                cfg_valid  = 1'b0;
    logic                cfg_ready;
    logic [CIDX_W-1:0]   cfg_index  = CFG_COLS;
    logic [CDATA_W-1:0]  cfg_data   = '0;

    text_console_wrap_scroll u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .char_code  (char_code),
        .read_row   (read_row),
        .read_col   (read_col),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_data  (read_data),
        .cursor_row (cursor_row),
        .cursor_col (cursor_col),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Screen model: own copy of the cell store, cursor and register values
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] screen [MAX_ROWS][ROW_LEN];
    int cur_line;
    int cur_col;
    int cols_in_use;
    int rows_in_use;

    reply_t replies_due[$];
    step_t  directed_plan[$];
    int     errors       = 0;
    int     results_seen = 0;
    int     cycles       = 0;
    int     burst_left   = 0;
    bit     steady       = 1'b0;

    // Blank the visible part of a line and terminate it at the active width
    function automatic void blank_line(input int r);
        if (r >= MAX_ROWS)
            return;
        for (int c = 0; c < cols_in_use; c++)
            screen[r][c] = CH_SPACE;
        screen[r][cols_in_use] = CH_NUL;
    endfunction

    // Move down a line, scrolling when the cursor sits on (or past) the last active row
    function automatic void advance_line();
        bit                ended;
        logic [BYTE_W-1:0] b;
        if (cur_line + 1 < rows_in_use)
            cur_line++;
        else
        begin
            for (int r = 0; r + 1 < rows_in_use; r++)
            begin
                ended = 1'b0;
                // copy up to the first zero, then pad with zeros
                for (int c = 0; c < ROW_LEN; c++)
                begin
                    b = ended ? CH_NUL : screen[r + 1][c];
                    if (b == CH_NUL)
                        ended = 1'b1;
                    screen[r][c] = b;
                end
            end
            blank_line(rows_in_use - 1);
            cur_line = rows_in_use - 1;
        end
        cur_col = 0;
        blank_line(cur_line);
    endfunction

    function automatic reply_t console_apply(input logic [TYPE_W-1:0] req,
                                             input logic [BYTE_W-1:0] ch,
                                             input logic [ROW_W-1:0]  rr,
                                             input logic [COL_W-1:0]  rc);
        reply_t r;
        r.data = CH_NUL;
        case (req)
            REQ_APPEND:
            begin
                if (ch == CH_NEWLINE)
                    advance_line();
                else
                begin
                    // a cursor at or past the width (e.g. after a narrower setting) wraps first
                    if (cur_col >= cols_in_use)
                        advance_line();
                    screen[cur_line][cur_col] = ch;
                    cur_col++;
                    screen[cur_line][cur_col] = CH_NUL;
                end
            end
            REQ_CLEAR:
            begin
                for (int i = 0; i < rows_in_use; i++)
                    blank_line(i);
                cur_line = 0;
                cur_col  = 0;
            end
            REQ_READ:
            begin
                // rows outside the active set stay readable; columns past the last cell of a row read zero
                if (int'(rr) < MAX_ROWS && int'(rc) < ROW_LEN)
                    r.data = screen[rr][rc];
            end
            default: ;
        endcase
        r.row = ROW_W'(cur_line);
        r.col = COL_W'(cur_col);
        return r;
    endfunction

    // Zero is taken as one; anything above the maximum saturates
    function automatic int clamp_reg(input int v, input int top);
        if (v == 0)
            return 1;
        if (v > top)
            return top;
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting
    // ------------------------------------------------------------------
    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        if (errors <= LOG_CAP)
            $display("[%0t] result %0d: %s got %0d, expected %0d",
                     $realtime, results_seen, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Result side: check each accepted result, then pick the next stall
    // ------------------------------------------------------------------
    int     stall_left = 0;
    int     stall_mode = 0;
    reply_t oldest;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (replies_due.size() == 0)
                report("result with no request pending, cursor_col", 32'(cursor_col), 32'd0);
            else
            begin
                oldest = replies_due.pop_front();
                if (read_data !== oldest.data)
                    report("read_data", 32'(read_data), 32'(oldest.data));
                if (cursor_row !== oldest.row)
                    report("cursor_row", 32'(cursor_row), 32'(oldest.row));
                if (cursor_col !== oldest.col)
                    report("cursor_col", 32'(cursor_col), 32'(oldest.col));
            end
        end

        // Stall pattern: free-running stretches, random flicker and solid holds
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = (stall_mode == 2) ? $urandom_range(1, 12) : $urandom_range(5, 40);
        end
        stall_left--;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= 1'($urandom_range(0, 1));
            default: out_stall <= 1'b1;
        endcase
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Hold the request until the block takes it, then predict its reply.
    // Valid is left high so back-to-back requests need no second assignment.
    task automatic issue(input step_t s);
        reply_t predicted;
        req_type  <= s.req;
        char_code <= s.ch;
        read_row  <= s.row;
        read_col  <= s.col;
        in_valid  <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        predicted = console_apply(s.req, s.ch, s.row, s.col);
        replies_due.push_back(s.typed ? s.want : predicted);
    endtask

    // Bursts of random length with random gaps; no gaps at all in steady phases
    task automatic pace_sender();
        if (steady)
            return;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        else
            burst_left--;
    endtask

    // Drop valid and let every outstanding reply arrive; the block is idle after that
    task automatic drain();
        in_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
    endtask

    // Write one register and mirror it in the model; valid stays high for a following write
    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_COLS)
            cols_in_use = clamp_reg(int'(val[COL_W-1:0]), MAX_COLS);
        else if (idx == CFG_ROWS)
            rows_in_use = clamp_reg(int'(val[AROW_W-1:0]), MAX_ROWS);
    endtask

    function automatic void plan_req(input logic typed, input logic [TYPE_W-1:0] req,
                                     input logic [BYTE_W-1:0] ch, input logic [ROW_W-1:0] rr,
                                     input logic [COL_W-1:0] rc, input logic [BYTE_W-1:0] d,
                                     input logic [ROW_W-1:0] crow, input logic [COL_W-1:0] ccol);
        step_t s;
        s.is_cfg    = 1'b0;
        s.typed     = typed;
        s.req       = req;
        s.ch        = ch;
        s.row       = rr;
        s.col       = rc;
        s.want.data = d;
        s.want.row  = crow;
        s.want.col  = ccol;
        directed_plan.push_back(s);
    endfunction

    function automatic void plan_cfg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] val);
        step_t s;
        s        = '0;
        s.is_cfg = 1'b1;
        s.row    = idx;
        s.ch     = val;
        directed_plan.push_back(s);
    endfunction

    // Mostly appends (text with newlines, now and then any byte), many reads,
    // rare clears and no-ops. Unused fields get random values too.
    function automatic step_t random_request();
        step_t s;
        int    pick;
        int    kind;
        s       = '0;
        s.ch    = BYTE_W'($urandom_range(0, 255));
        s.row   = ROW_W'($urandom_range(0, MAX_ROWS - 1));
        s.col   = ($urandom_range(0, 7) == 0) ? COL_W'($urandom_range(ROW_LEN, 31))
                                               : COL_W'($urandom_range(0, MAX_COLS));
        pick    = $urandom_range(0, 99);
        if (pick < 62)
        begin
            s.req = REQ_APPEND;
            kind  = $urandom_range(0, 9);
            if (kind < 2)
                s.ch = CH_NEWLINE;
            else if (kind > 2)
                s.ch = BYTE_W'($urandom_range(33, 126));
        end
        else if (pick < 64)
            s.req = REQ_CLEAR;
        else if (pick < 67)
            s.req = REQ_NOP;
        else
            s.req = REQ_READ;
        return s;
    endfunction

    initial
    begin
        step_t s;
        int    ph;
        int    n;
        logic [CDATA_W-1:0] cols_val;
        logic [CDATA_W-1:0] rows_val;

        // Model state after reset: spaces up to the reset width, zeros beyond
        cols_in_use = RESET_COLS;
        rows_in_use = RESET_ROWS;
        cur_line    = 0;
        cur_col     = 0;
        for (int r = 0; r < MAX_ROWS; r++)
            for (int c = 0; c < ROW_LEN; c++)
                screen[r][c] = (c < cols_in_use) ? CH_SPACE : CH_NUL;

        // Directed plan. Fresh screen: spaces, terminator cell zero, out-of-range column zero.
        plan_req(1'b1, REQ_READ,   CH_NUL,     2'd0, 5'd0,  CH_SPACE, 2'd0, 5'd0);
        plan_req(1'b1, REQ_READ,   CH_NUL,     2'd3, 5'd19, CH_SPACE, 2'd0, 5'd0);
        plan_req(1'b1, REQ_READ,   CH_NUL,     2'd3, 5'd20, CH_NUL,   2'd0, 5'd0);
        plan_req(1'b1, REQ_READ,   CH_NUL,     2'd2, 5'd31, CH_NUL,   2'd0, 5'd0);
        plan_req(1'b1, REQ_NOP,    8'hFF,      2'd3, 5'd31, CH_NUL,   2'd0, 5'd0);
        // Append stores at the cursor and terminates behind it; zero and 0xFF are plain bytes
        plan_req(1'b1, REQ_APPEND, 8'd65,      2'd0, 5'd0,  CH_NUL,   2'd0, 5'd1);
        plan_req(1'b1, REQ_READ,   CH_NUL,     2'd0, 5'd0,  8'd65,    2'd0, 5'd1);
        plan_req(1'b1, REQ_READ,   CH_NUL,     2'd0, 5'd1,  CH_NUL,   2'd0, 5'd1);
        plan_req(1'b1, REQ_APPEND, CH_NUL,     2'd0, 5'd0,  CH_NUL,   2'd0, 5'd2);
        plan_req(1'b1, REQ_APPEND, 8'hFF,      2'd0, 5'd0,  CH_NUL,   2'd0, 5'd3);
        plan_req(1'b1, REQ_APPEND, CH_NEWLINE, 2'd0, 5'd0,  CH_NUL,   2'd1, 5'd0);
        plan_req(1'b1, REQ_READ,   CH_NUL,     2'd1, 5'd0,  CH_SPACE, 2'd1, 5'd0);
        plan_req(1'b0, REQ_READ,   CH_NUL,     2'd0, 5'd2,  CH_NUL,   2'd0, 5'd0);
        plan_req(1'b1, REQ_CLEAR,  CH_NUL,     2'd0, 5'd0,  CH_NUL,   2'd0, 5'd0);
        plan_req(1'b1, REQ_READ,   CH_NUL,     2'd0, 5'd0,  CH_SPACE, 2'd0, 5'd0);
        // Zero written to both registers is taken as one; the spare index changes nothing
        plan_cfg(CFG_COLS, 8'h00);
        plan_cfg(CFG_ROWS, 8'h00);
        plan_cfg(CFG_UNUSED, 8'h5A);
        // One-cell screen: the second byte wraps, and the wrap scrolls in place
        plan_req(1'b1, REQ_APPEND, 8'd120,     2'd0, 5'd0,  CH_NUL,   2'd0, 5'd1);
        plan_req(1'b1, REQ_APPEND, 8'd121,     2'd0, 5'd0,  CH_NUL,   2'd0, 5'd1);
        plan_req(1'b1, REQ_READ,   CH_NUL,     2'd0, 5'd0,  8'd121,   2'd0, 5'd1);
        plan_req(1'b1, REQ_APPEND, CH_NEWLINE, 2'd0, 5'd0,  CH_NUL,   2'd0, 5'd0);
        plan_req(1'b1, REQ_READ,   CH_NUL,     2'd0, 5'd0,  CH_SPACE, 2'd0, 5'd0);
        plan_req(1'b0, REQ_READ,   CH_NUL,     2'd0, 5'd2,  CH_NUL,   2'd0, 5'd0);
        // All ones saturate to the full geometry; the text already held is kept
        plan_cfg(CFG_COLS, 8'hFF);
        plan_cfg(CFG_ROWS, 8'hFF);
        plan_req(1'b1, REQ_APPEND, 8'd122,     2'd0, 5'd0,  CH_NUL,   2'd0, 5'd1);
        plan_req(1'b1, REQ_READ,   CH_NUL,     2'd0, 5'd1,  CH_NUL,   2'd0, 5'd1);
        plan_req(1'b0, REQ_READ,   CH_NUL,     2'd3, 5'd20, CH_NUL,   2'd0, 5'd0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed plan; registers are only touched once the block is idle
        for (int i = 0; i < directed_plan.size(); i++)
        begin
            s = directed_plan[i];
            if (s.is_cfg)
            begin
                drain();
                write_reg(s.row, s.ch);
            end
            else
            begin
                cfg_valid <= 1'b0;
                issue(s);
                pace_sender();
            end
        end

        // Random phases, each under its own geometry. No clear between phases, so
        // text and cursor carry over into narrower or shorter settings.
        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       begin cols_val = 8'd20; rows_val = 8'd4; end
                1:       begin cols_val = 8'd1;  rows_val = 8'd1; end
                2:       begin cols_val = 8'd20; rows_val = 8'd1; end
                3:       begin cols_val = 8'd1;  rows_val = 8'd4; end
                4:       begin cols_val = 8'd7;  rows_val = 8'd2; end
                5:       begin cols_val = 8'd3;  rows_val = 8'd3; end
                default:
                begin
                    cols_val = CDATA_W'($urandom_range(0, 255));
                    rows_val = CDATA_W'($urandom_range(0, 255));
                end
            endcase
            drain();
            write_reg(CFG_COLS, cols_val);
            write_reg(CFG_ROWS, rows_val);
            cfg_valid <= 1'b0;

            steady     = (ph % 3 == 1);
            burst_left = 0;
            for (n = 0; n < PHASE_REQS; n++)
            begin
                issue(random_request());
                pace_sender();
            end
        end

        // Let the last replies out, then hold a little longer for stray results
        drain();
        repeat (100) @(posedge clk);

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[filelist.f]
design/tcws_pkg.sv
design/tcws_cell_ram.sv
design/text_console_wrap_scroll.sv
design/tcws_checker.sv
bench/text_console_wrap_scroll_tb.sv
